// ===== hw/rtl/lpht_pkg.sv =====
// Shared constants, codes and helper functions for the linear-probing hash table.
// Used by lpht_hash and linear_probe_hash_table_core; no dependencies.
package lpht_pkg;

  localparam int SLOTS     = 1024;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int KEY_BYTES = 8;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int VAL_W     = 32;
  localparam int ENT_W     = KEY_W + VAL_W;
  localparam int ACT_W     = 3;
  localparam int IN_W      = 104;
  localparam int OUT_W     = 120;
  localparam int HASH_W    = 64;
  localparam int HCNT_W    = $clog2(HASH_W);

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(SLOTS);
  localparam logic [7:0] FOLD_DELTA = 8'd32;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5A;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_SEARCH = 3'd1,
    ACT_ERASE  = 3'd2,
    ACT_FIRST  = 3'd3,
    ACT_NEXT   = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_LIVE    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2,
    STAT_MISS = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_ADDR,
    ST_EVAL,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_HASH,
    HS_DIV,
    HS_DONE
  } hash_state_t;

  // Map upper-case ASCII to lower case, keep everything else
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    fold_byte = (b >= UPPER_A && b <= UPPER_Z) ? b + FOLD_DELTA : b;
  endfunction

  // Zero every byte from the first zero byte on
  function automatic logic [KEY_W-1:0] clean_key(input logic [KEY_W-1:0] raw);
    logic alive;
    logic [KEY_W-1:0] k;
    alive = 1'b1;
    k = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (raw[8*i +: 8] == 8'd0) alive = 1'b0;
      if (alive) k[8*i +: 8] = raw[8*i +: 8];
    end
    clean_key = k;
  endfunction

endpackage

// ===== hw/rtl/lpht_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lpht_hash.sv =====
// Home slot unit: byte-serial multiply-by-33 hash, then a bit-serial remainder by capacity.
// Depends on lpht_pkg.
module lpht_hash (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lpht_pkg::KEY_W-1:0]   key_in,
  input  logic [lpht_pkg::CNT_W-1:0]   cap_in,
  output logic                         done,
  output logic [lpht_pkg::SLOT_W-1:0]  home
);
  import lpht_pkg::*;

  hash_state_t state, state_next;
  logic [HCNT_W-1:0] cnt;
  logic [KEY_W-1:0]  key_sh;
  logic [HASH_W-1:0] h;
  logic [CNT_W-1:0]  cap;
  logic [7:0]        cur_byte;
  logic              last_byte;
  logic [CNT_W-1:0]  rem_w;

  assign cur_byte  = key_sh[7:0];
  assign last_byte = (cur_byte == 8'd0) || (cnt == HCNT_W'(KEY_BYTES - 1));
  assign rem_w     = {home, h[HASH_W-1]};

  // Next phase
  always_comb begin
    state_next = state;
    case (state)
      HS_IDLE: if (start) state_next = HS_HASH;
      HS_HASH: if (last_byte) state_next = HS_DIV;
      HS_DIV:  if (cnt == HCNT_W'(HASH_W - 1)) state_next = HS_DONE;
      HS_DONE: state_next = HS_IDLE;
      default: state_next = HS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done = (state == HS_DONE);
  end

  // Hash accumulate, then shift the hash out MSB first into the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HS_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      HS_IDLE: begin
        cnt    <= '0;
        key_sh <= key_in;
        cap    <= cap_in;
        h      <= '0;
        home   <= '0;
      end
      HS_HASH: begin
        if (cur_byte != 8'd0) h <= (h << 5) + h + HASH_W'(fold_byte(cur_byte));
        key_sh <= key_sh >> 8;
        cnt    <= last_byte ? '0 : cnt + 1'b1;
      end
      HS_DIV: begin
        home <= (rem_w >= cap) ? SLOT_W'(rem_w - cap) : SLOT_W'(rem_w);
        h    <= h << 1;
        cnt  <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/linear_probe_hash_table_core.sv =====
// Hash table core: request sequencer, slot mark RAM and key/value RAM.
// Depends on lpht_pkg, lpht_ram and lpht_hash.
//
// Open-addressing hash table with linear probing over up to 1024 slots. After reset a
// clearing pass marks every slot empty, one slot a cycle; s_tready stays low during it.
// Requests are handled one at a time. Insert, search and erase first compute the home slot:
// hashing of up to eight key bytes (one key byte a cycle), remainder by capacity over the
// 64 hash bits (one hash bit a cycle) and a handoff state. Each probed slot then takes a RAM
// read state and an evaluate state, an insert adds a write state, and the result is then
// loaded into the output register once the output side is free. First/next entry walks
// skip hashing and take the read and evaluate states for each slot scanned. A new request
// is taken while the previous result still waits on m_tready.
module linear_probe_hash_table_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lpht_pkg::CNT_W-1:0] cfg_data,   // table_capacity
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // action[2:0], key_chars[66:3], value[98:67], zero fill[103:99]
  input  logic [lpht_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // found[0], key_out[64:1], value_out[96:65], slot_index[106:97], status[108:107],
  // entry_count[119:109]
  output logic [lpht_pkg::OUT_W-1:0] m_tdata
);
  import lpht_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]  cap_reg;
  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W-1:0]  clr_cnt;
  logic [ACT_W-1:0]  act_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  val_r;
  logic [SLOT_W-1:0] home;
  logic [CNT_W-1:0]  idx;
  logic [SLOT_W-1:0] cursor;
  logic              cursor_vld;
  logic [CNT_W-1:0]  live;

  logic              res_found;
  logic [KEY_W-1:0]  res_key;
  logic [VAL_W-1:0]  res_val;
  logic [SLOT_W-1:0] res_slot;
  logic [1:0]        res_stat;

  logic              mark_we;
  logic [SLOT_W-1:0] mark_waddr;
  logic [1:0]        mark_wdata;
  logic [1:0]        mark_rdata;
  logic              ent_we;
  logic [ENT_W-1:0]  ent_rdata;

  logic              hash_start;
  logic              hash_done;
  logic [SLOT_W-1:0] hash_home;

  logic              accept;
  logic [ACT_W-1:0]  in_act;
  logic              is_walk;
  logic              slot_live;
  logic              slot_empty;
  logic              key_eq;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  idx_wrap;
  logic              at_home;
  logic              out_free;

  assign cap_eff = (cap_reg == '0) ? CNT_W'(1) :
                   (cap_reg > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cap_reg;

  assign accept     = s_tvalid && s_tready;
  assign in_act     = s_tdata[ACT_W-1:0];
  assign hash_start = accept && (in_act <= ACT_ERASE);
  assign is_walk    = (act_r == ACT_FIRST) || (act_r == ACT_NEXT);
  assign slot_live  = (mark_rdata == MARK_LIVE);
  assign slot_empty = (mark_rdata == MARK_EMPTY);
  assign key_eq     = (ent_rdata[KEY_W-1:0] == key_r);
  assign idx_inc    = idx + 1'b1;
  assign idx_wrap   = (idx_inc == cap_eff) ? '0 : idx_inc;
  assign at_home    = (idx_wrap[SLOT_W-1:0] == home);
  assign out_free   = !m_tvalid || m_tready;

  lpht_hash u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .key_in (clean_key(s_tdata[ACT_W +: KEY_W])),
    .cap_in (cap_eff),
    .done   (hash_done),
    .home   (hash_home)
  );

  lpht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (idx[SLOT_W-1:0]),
    .rdata (mark_rdata)
  );

  lpht_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (idx[SLOT_W-1:0]),
    .wdata ({val_r, key_r}),
    .raddr (idx[SLOT_W-1:0]),
    .rdata (ent_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == CNT_W'(SLOTS - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (s_tvalid) begin
          if (in_act <= ACT_ERASE) state_next = ST_HASH;
          else if (in_act == ACT_FIRST || in_act == ACT_NEXT) state_next = ST_ADDR;
          else state_next = ST_DONE;
        end
      end
      ST_HASH: if (hash_done) state_next = ST_ADDR;
      ST_ADDR: state_next = (is_walk && idx >= cap_eff) ? ST_DONE : ST_EVAL;
      ST_EVAL: begin
        case (act_r)
          ACT_INSERT: begin
            if (!slot_live) state_next = ST_WRITE;
            else if (key_eq || at_home) state_next = ST_DONE;
            else state_next = ST_ADDR;
          end
          ACT_SEARCH, ACT_ERASE: begin
            if (slot_empty || (slot_live && key_eq) || at_home) state_next = ST_DONE;
            else state_next = ST_ADDR;
          end
          ACT_FIRST, ACT_NEXT: state_next = slot_live ? ST_DONE : ST_ADDR;
          default: state_next = ST_DONE;
        endcase
      end
      ST_WRITE: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs: handshake and RAM writes
  always_comb begin
    s_tready   = (state == ST_IDLE);
    mark_we    = 1'b0;
    mark_waddr = idx[SLOT_W-1:0];
    mark_wdata = MARK_EMPTY;
    ent_we     = 1'b0;
    case (state)
      ST_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_cnt[SLOT_W-1:0];
      end
      ST_EVAL: begin
        if (act_r == ACT_ERASE && slot_live && key_eq) begin
          mark_we    = 1'b1;
          mark_wdata = MARK_DELETED;
        end
      end
      ST_WRITE: begin
        mark_we    = 1'b1;
        mark_wdata = MARK_LIVE;
        ent_we     = 1'b1;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      cap_reg    <= CAP_RESET;
      cursor_vld <= 1'b0;
      live       <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) cap_reg <= cfg_data;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      // Raise valid on a finished request, drop it once the transaction is taken
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_EVAL: begin
          if (slot_live && ((act_r == ACT_SEARCH && key_eq) || is_walk)) cursor_vld <= 1'b1;
          if (act_r == ACT_ERASE && slot_live && key_eq && live != '0) live <= live - 1'b1;
        end
        ST_WRITE: begin
          cursor_vld <= 1'b1;
          live       <= live + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        act_r     <= in_act;
        key_r     <= clean_key(s_tdata[ACT_W +: KEY_W]);
        val_r     <= s_tdata[ACT_W+KEY_W +: VAL_W];
        idx       <= (in_act == ACT_NEXT && cursor_vld) ? {1'b0, cursor} + 1'b1 : '0;
        res_found <= 1'b0;
        res_key   <= '0;
        res_val   <= '0;
        res_slot  <= '0;
        res_stat  <= STAT_MISS;
      end
      ST_HASH: begin
        if (hash_done) begin
          home     <= hash_home;
          idx      <= {1'b0, hash_home};
          res_slot <= hash_home;
        end
      end
      ST_EVAL: begin
        case (act_r)
          ACT_INSERT: begin
            if (slot_live && key_eq) begin
              res_found <= 1'b1;
              res_key   <= ent_rdata[KEY_W-1:0];
              res_val   <= ent_rdata[KEY_W +: VAL_W];
              res_slot  <= idx[SLOT_W-1:0];
              res_stat  <= STAT_DUP;
            end else if (slot_live && at_home) begin
              res_stat <= STAT_FULL;
            end else if (slot_live) begin
              idx <= idx_wrap;
            end
          end
          ACT_SEARCH, ACT_ERASE: begin
            if (slot_live && key_eq) begin
              res_found <= 1'b1;
              res_key   <= ent_rdata[KEY_W-1:0];
              res_val   <= ent_rdata[KEY_W +: VAL_W];
              res_slot  <= idx[SLOT_W-1:0];
              res_stat  <= STAT_OK;
              if (act_r == ACT_SEARCH) cursor <= idx[SLOT_W-1:0];
            end else if (!slot_empty && !at_home) begin
              idx <= idx_wrap;
            end
          end
          ACT_FIRST, ACT_NEXT: begin
            if (slot_live) begin
              res_found <= 1'b1;
              res_key   <= ent_rdata[KEY_W-1:0];
              res_val   <= ent_rdata[KEY_W +: VAL_W];
              res_slot  <= idx[SLOT_W-1:0];
              res_stat  <= STAT_OK;
              cursor    <= idx[SLOT_W-1:0];
            end else begin
              idx <= idx_inc;
            end
          end
          default: ;
        endcase
      end
      ST_WRITE: begin
        res_found <= 1'b1;
        res_key   <= key_r;
        res_val   <= val_r;
        res_slot  <= idx[SLOT_W-1:0];
        res_stat  <= STAT_OK;
        cursor    <= idx[SLOT_W-1:0];
      end
      ST_DONE: begin
        if (out_free) m_tdata <= {live, res_stat, res_slot, res_val, res_key, res_found};
      end
      default: ;
    endcase
  end

  // Entry count never exceeds the slot count
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= CNT_W'(SLOTS)) else $error("live count above slot count");

  // Probes stay inside the active capacity
  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |-> idx < cap_eff) else $error("probe index outside capacity");

  // A new result appears only after the sequencer finished a request
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE)) else $error("result loaded outside done");

  // An insert write adds exactly one live entry
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |=> live == $past(live) + 1'b1) else $error("insert count mismatch");

  // No request is taken during the clearing pass
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !s_tready)
    else $error("request accepted while clearing");

endmodule

// ===== tb/linear_probe_hash_table_core_tb.sv =====
// Testbench for linear_probe_hash_table_core: directed table, then random phases at
// several table capacities, checked against an in-bench model or fixed expected rows.
// Depends on lpht_pkg and the core RTL.
`timescale 1ns / 1ps

module linear_probe_hash_table_core_tb;
  import lpht_pkg::*;

  localparam logic [2:0] ACT_BAD   = 3'd7;   // unknown action code
  localparam logic [2:0] ACT_SPARE = 3'd5;   // lowest unknown action code
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic                 found;
    logic [KEY_W-1:0]     key;
    logic [VAL_W-1:0]     val;
    logic [SLOT_W-1:0]    slot;
    stat_t                status;
    logic [CNT_W-1:0]     count;
  } lookup_t;

  typedef struct {
    logic [2:0]       act;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic             fixed;
    lookup_t          want;
  } req_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  linear_probe_hash_table_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Table mirror
  mark_t            mir_mark [SLOTS];
  logic [KEY_W-1:0] mir_key  [SLOTS];
  logic [VAL_W-1:0] mir_val  [SLOTS];
  int unsigned      cursor;
  logic             cursor_ok;
  int unsigned      live;
  logic [CNT_W-1:0] cap_reg;

  lookup_t pending_results[$];
  int  mismatches = 0;
  logic quiet = 1'b0;
  logic [KEY_W-1:0] key_pool[48];

  function automatic int unsigned usable_cap();
    if (cap_reg == 0) return 1;
    if (cap_reg > SLOTS) return SLOTS;
    return cap_reg;
  endfunction

  function automatic logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (raw[8*i +: 8] == 8'd0) break;
      k[8*i +: 8] = raw[8*i +: 8];
    end
    return k;
  endfunction

  function automatic int unsigned home_of(logic [KEY_W-1:0] k, int unsigned cap);
    logic [63:0] h;
    logic [7:0] b;
    h = '0;
    for (int i = 0; i < 8; i++) begin
      b = k[8*i +: 8];
      if (b == 8'd0) break;
      if (b >= 8'h41 && b <= 8'h5A) b = b + 8'd32;
      h = h * 64'd33 + 64'(b);
    end
    return int'(h % 64'(cap));
  endfunction

  // Apply one request to the mirror and return its result
  function automatic lookup_t table_lookup(logic [2:0] act, logic [KEY_W-1:0] raw,
                                           logic [VAL_W-1:0] v);
    lookup_t r;
    logic [KEY_W-1:0] k;
    int unsigned cap, home, idx, from;
    int hit;
    logic done;
    r = '{found: 1'b0, key: '0, val: '0, slot: '0, status: STAT_MISS, count: '0};
    k = trim_key(raw);
    cap = usable_cap();
    home = 0;
    if (act <= ACT_ERASE) home = home_of(k, cap);
    r.slot = SLOT_W'(home);
    if (act == ACT_INSERT) begin
      idx = home;
      done = 1'b0;
      while (mir_mark[idx] == MARK_LIVE) begin
        if (mir_key[idx] == k) begin
          r.found = 1'b1; r.status = STAT_DUP; r.slot = SLOT_W'(idx);
          r.key = mir_key[idx]; r.val = mir_val[idx];
          done = 1'b1;
          break;
        end
        idx = (idx + 1) % cap;
        if (idx == home) begin
          r.status = STAT_FULL; done = 1'b1;
          break;
        end
      end
      if (!done) begin
        mir_key[idx] = k; mir_val[idx] = v; mir_mark[idx] = MARK_LIVE;
        live++;
        cursor = idx; cursor_ok = 1'b1;
        r.found = 1'b1; r.status = STAT_OK; r.slot = SLOT_W'(idx); r.key = k; r.val = v;
      end
    end else if (act == ACT_SEARCH || act == ACT_ERASE) begin
      hit = -1;
      idx = home;
      while (mir_mark[idx] != MARK_EMPTY) begin
        if (mir_mark[idx] == MARK_LIVE && mir_key[idx] == k) begin
          hit = idx;
          break;
        end
        idx = (idx + 1) % cap;
        if (idx == home) break;
      end
      if (hit >= 0) begin
        r.found = 1'b1; r.status = STAT_OK; r.slot = SLOT_W'(hit);
        r.key = mir_key[hit]; r.val = mir_val[hit];
        if (act == ACT_SEARCH) begin
          cursor = hit; cursor_ok = 1'b1;
        end else begin
          mir_mark[hit] = MARK_DELETED;
          if (live > 0) live--;
        end
      end
    end else if (act == ACT_FIRST || act == ACT_NEXT) begin
      from = (act == ACT_NEXT && cursor_ok) ? cursor + 1 : 0;
      for (int unsigned i = from; i < cap; i++) begin
        if (mir_mark[i] == MARK_LIVE) begin
          cursor = i; cursor_ok = 1'b1;
          r.found = 1'b1; r.status = STAT_OK; r.slot = SLOT_W'(i);
          r.key = mir_key[i]; r.val = mir_val[i];
          break;
        end
      end
    end
    r.count = CNT_W'(live);
    return r;
  endfunction

  // Drive one request; valid stays high after acceptance until a gap or drain
  task automatic send_request(logic [2:0] act, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                              logic fixed, lookup_t want);
    lookup_t r;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, v, k, act};
    do @(posedge clk); while (!s_tready);
    r = table_lookup(act, k, v);
    pending_results.push_back(fixed ? want : r);
  endtask

  // Stop driving and wait for every result before touching the register
  task automatic drain_requests();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] c);
    drain_requests();
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cap_reg = c;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 6) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, 47)];
  endfunction

  function automatic logic [2:0] pick_action();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 36) return ACT_INSERT;
    if (p < 56) return ACT_SEARCH;
    if (p < 74) return ACT_ERASE;
    if (p < 81) return ACT_FIRST;
    if (p < 95) return ACT_NEXT;
    return 3'($urandom_range(5, 7));
  endfunction

  // Result side: random stall bursts, compare each transaction with the oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    lookup_t got, want;
    if (m_tvalid && m_tready) begin
      got = '{found: m_tdata[0], key: m_tdata[64:1], val: m_tdata[96:65],
              slot: m_tdata[106:97], status: stat_t'(m_tdata[108:107]),
              count: m_tdata[119:109]};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found || got.key !== want.key || got.val !== want.val ||
            got.slot !== want.slot || got.status !== want.status ||
            got.count !== want.count) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  localparam lookup_t NONE_EMPTY =
    '{found: 1'b0, key: '0, val: '0, slot: '0, status: STAT_MISS, count: '0};

  // Directed table; capacity is at its reset value of 1024
  req_row_t rows[] = '{
    '{ACT_FIRST,  64'h0,                  32'h0,          1'b1, NONE_EMPTY},
    '{ACT_NEXT,   64'h0,                  32'h0,          1'b1, NONE_EMPTY},
    '{ACT_BAD,    64'h636261,             32'h1,          1'b1, NONE_EMPTY},
    '{ACT_SEARCH, 64'h636261,             32'h0,          1'b0, NONE_EMPTY},  // "abc"
    '{ACT_INSERT, 64'h0,                  32'h0,          1'b0, NONE_EMPTY},  // empty key
    '{ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NONE_EMPTY},
    '{ACT_INSERT, 64'h434241,             32'h1111,       1'b0, NONE_EMPTY},  // "ABC"
    '{ACT_INSERT, 64'h636261,             32'h2222,       1'b0, NONE_EMPTY},  // same home
    '{ACT_INSERT, 64'h434241,             32'h3333,       1'b0, NONE_EMPTY},  // duplicate
    '{ACT_INSERT, 64'h6200_0000_0000_0061, 32'h4444,      1'b0, NONE_EMPTY},  // "a" then junk
    '{ACT_INSERT, 64'h61,                 32'h5555,       1'b0, NONE_EMPTY},  // duplicate "a"
    '{ACT_SEARCH, 64'h636261,             32'h0,          1'b0, NONE_EMPTY},
    '{ACT_SEARCH, 64'h5A5A5A,             32'h0,          1'b0, NONE_EMPTY},  // miss
    '{ACT_ERASE,  64'h434241,             32'h0,          1'b0, NONE_EMPTY},
    '{ACT_ERASE,  64'h434241,             32'h0,          1'b0, NONE_EMPTY},  // miss
    '{ACT_SEARCH, 64'h636261,             32'h0,          1'b0, NONE_EMPTY},  // past deleted
    '{ACT_INSERT, 64'h434241,             32'h6666,       1'b0, NONE_EMPTY},  // reuse deleted
    '{ACT_FIRST,  64'h0,                  32'h0,          1'b0, NONE_EMPTY},
    '{ACT_NEXT,   64'h0,                  32'h0,          1'b0, NONE_EMPTY},
    '{ACT_NEXT,   64'h0,                  32'h0,          1'b0, NONE_EMPTY},
    '{ACT_NEXT,   64'h0,                  32'h0,          1'b0, NONE_EMPTY},
    '{ACT_NEXT,   64'h0,                  32'h0,          1'b0, NONE_EMPTY},
    '{ACT_NEXT,   64'h0,                  32'h0,          1'b0, NONE_EMPTY},
    '{ACT_SPARE,  64'h61,                 32'h7,          1'b0, NONE_EMPTY}
  };

  // Capacities per random phase: extremes, out-of-range values, small and full tables
  logic [CNT_W-1:0] phase_caps[] = '{11'd1, 11'd0, 11'd2, 11'd7, 11'd2047, 11'd16,
                                     11'd33, 11'd1000, 11'd12, 11'd1024};

  initial begin
    logic [7:0] alphabet[10];
    int len;
    alphabet = '{8'h41, 8'h61, 8'h42, 8'h62, 8'h5A, 8'h7A, 8'h40, 8'h5B, 8'h30, 8'hFF};
    for (int i = 0; i < SLOTS; i++) begin
      mir_mark[i] = MARK_EMPTY;
      mir_key[i] = '0;
      mir_val[i] = '0;
    end
    cursor = 0; cursor_ok = 1'b0; live = 0; cap_reg = CAP_RESET;
    // Short keys from a small alphabet so that duplicates and collisions are common
    foreach (key_pool[i]) begin
      key_pool[i] = '0;
      len = $urandom_range(0, 8);
      for (int j = 0; j < len; j++) key_pool[i][8*j +: 8] = alphabet[$urandom_range(0, 9)];
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_request(rows[i].act, rows[i].key, rows[i].val,
                                   rows[i].fixed, rows[i].want);

    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      if (p == phase_caps.size() - 1) quiet = 1'b1;
      repeat (80) send_request(pick_action(), pick_key(), $urandom, 1'b0, NONE_EMPTY);
    end

    drain_requests();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
